>>> src/lgs_pkg.sv
// Shared types, constants and the Life rule for the grid generation block.
package lgs_pkg;

	localparam int GRID_SIZE = 10;
	localparam int ROW_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
	localparam int OPCODE_W  = 2;
	localparam int ROW_IDX_W = 4;
	localparam int FIELD_W   = 10;
	localparam int COUNT_W   = 32;

	typedef logic [GRID_SIZE-1:0] grid_row_t;
	typedef logic [FIELD_W-1:0]   field_row_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic do_write;
		logic do_step;
	} dp_cmd_t;

	// next state of one cell from its own state and its eight neighbours
	function automatic logic life_rule(input logic alive, input logic [7:0] nbrs);
		logic [3:0] n;
		n = 4'($countones(nbrs));
		return alive ? ((n == 4'd2) || (n == 4'd3)) : (n == 4'd3);
	endfunction

endpackage

>>> src/lgs_in_if.sv
// Request channel: opcode, row index and row cells with valid/ready.
interface lgs_in_if
	import lgs_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [OPCODE_W-1:0]  opcode;
	logic [ROW_IDX_W-1:0] row_index;
	logic [FIELD_W-1:0]   row_cells;

	modport source (output valid, output opcode, output row_index, output row_cells,
		input ready);
	modport sink (input valid, input opcode, input row_index, input row_cells,
		output ready);
endinterface

>>> src/lgs_out_if.sv
// Response channel: row and generation count with valid/ready.
interface lgs_out_if
	import lgs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] row_out;
	logic [COUNT_W-1:0] generation_count;

	modport source (output valid, output row_out, output generation_count, input ready);
	modport sink (input valid, input row_out, input generation_count, output ready);
endinterface

>>> src/lgs_ctrl.sv
// Controller: request acceptance, response occupancy and operation decode.
module lgs_ctrl
	import lgs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	output logic                out_valid,
	input  logic                out_ready,
	output dp_cmd_t             cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        accept;

	// a new transaction may enter in the cycle the held response leaves
	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_FULL);

	always_comb begin
		cmd.load     = accept;
		cmd.do_write = 1'b0;
		cmd.do_step  = 1'b0;
		unique case (opcode_t'(opcode))
			OP_WRITE: cmd.do_write = accept;
			OP_STEP:  cmd.do_step  = accept;
			default:  ;
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_EMPTY: if (accept) state_nxt = ST_FULL;
			ST_FULL: begin
				if (accept) state_nxt = ST_FULL;
				else if (out_ready) state_nxt = ST_EMPTY;
			end
			default: state_nxt = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> src/lgs_dp.sv
// Datapath: cell grid, parallel Life update, row access and generation counter.
module lgs_dp
	import lgs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic [ROW_IDX_W-1:0] row_index,
	input  logic [FIELD_W-1:0]   row_cells,
	output logic [FIELD_W-1:0]   row_out,
	output logic [COUNT_W-1:0]   generation_count
);

	grid_row_t          grid_q [GRID_SIZE];
	grid_row_t          grid_nxt [GRID_SIZE];
	grid_row_t          life_grid [GRID_SIZE];
	grid_row_t          wr_row;
	grid_row_t          sel_row;
	logic [ROW_W-1:0]   row_sel;
	logic               row_ok;
	logic [FIELD_W-1:0] row_out_q;
	logic [COUNT_W-1:0] count_q;

	assign row_ok  = {26'd0, row_index} < 30'(GRID_SIZE);
	assign row_sel = ROW_W'(row_index);

	// columns beyond the request field are written dead
	always_comb begin
		for (int c = 0; c < GRID_SIZE; c++) begin
			wr_row[c] = (c < FIELD_W) ? row_cells[c % FIELD_W] : 1'b0;
		end
	end

	// border cells keep their values; every interior cell updates at once
	always_comb begin
		for (int r = 0; r < GRID_SIZE; r++) begin
			life_grid[r] = grid_q[r];
		end
		for (int r = 1; r < GRID_SIZE - 1; r++) begin
			for (int c = 1; c < GRID_SIZE - 1; c++) begin
				life_grid[r][c] = life_rule(grid_q[r][c], {
					grid_q[r-1][c-1], grid_q[r-1][c], grid_q[r-1][c+1],
					grid_q[r][c-1],                   grid_q[r][c+1],
					grid_q[r+1][c-1], grid_q[r+1][c], grid_q[r+1][c+1]});
			end
		end
	end

	always_comb begin
		for (int r = 0; r < GRID_SIZE; r++) begin
			if (cmd.do_step) begin
				grid_nxt[r] = life_grid[r];
			end else if (cmd.do_write && row_ok && (row_sel == ROW_W'(r))) begin
				grid_nxt[r] = wr_row;
			end else begin
				grid_nxt[r] = grid_q[r];
			end
		end
	end

	always_comb begin
		sel_row = grid_nxt[row_sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < GRID_SIZE; r++) begin
				grid_q[r] <= '0;
			end
			count_q <= '0;
		end else begin
			if (cmd.load) begin
				for (int r = 0; r < GRID_SIZE; r++) begin
					grid_q[r] <= grid_nxt[r];
				end
			end
			if (cmd.do_step) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < FIELD_W; k++) begin
				row_out_q[k] <= (row_ok && (k < GRID_SIZE)) ? sel_row[k % GRID_SIZE] : 1'b0;
			end
		end
	end

	assign row_out          = row_out_q;
	assign generation_count = count_q;

endmodule

>>> src/life_grid_generation_step.sv
// Top level of the Life grid block: controller plus grid datapath.
//
//  port  dir   fields                        meaning
//  cmd   sink  opcode, row_index, row_cells  write row, step generation, read row
//  rsp   src   row_out, generation_count     addressed row after the op, count
//
// For each transaction the whole grid updates in parallel in the datapath and
// the response lands in an output register at the accept edge.
// A new request is taken in the same cycle the held response is consumed.
// While the response is stalled, cmd.ready stays low.
// Reset clears the grid to all dead and the generation count to zero.
module life_grid_generation_step
	import lgs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	lgs_in_if.sink    cmd,
	lgs_out_if.source rsp
);

	dp_cmd_t dp_cmd;

	lgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.opcode    (cmd.opcode),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (dp_cmd)
	);

	lgs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (dp_cmd),
		.row_index        (cmd.row_index),
		.row_cells        (cmd.row_cells),
		.row_out          (rsp.row_out),
		.generation_count (rsp.generation_count)
	);

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for the Life grid block: directed and random row/step traffic.
module tb
	import lgs_pkg::*;
;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int PHASES = 4;

	typedef struct {
		field_row_t         row;
		logic [COUNT_W-1:0] count;
	} life_rsp_t;

	// grid shadow plus the queue of responses still owed by the block
	class life_scoreboard;
		grid_row_t          cells [GRID_SIZE];
		logic [COUNT_W-1:0] gens;
		life_rsp_t          pending [$];
		int                 fails;

		function new();
			foreach (cells[r]) cells[r] = '0;
			gens = '0;
			fails = 0;
		endfunction

		function void note_request(logic [OPCODE_W-1:0] op, logic [ROW_IDX_W-1:0] row,
			field_row_t data);
			grid_row_t prev [GRID_SIZE];
			int        n;
			life_rsp_t exp;
			if (op == OP_WRITE) begin
				if (row < GRID_SIZE) cells[row] = grid_row_t'(data);
			end else if (op == OP_STEP) begin
				prev = cells;
				// border rows and columns keep their values
				for (int r = 1; r < GRID_SIZE - 1; r++) begin
					for (int c = 1; c < GRID_SIZE - 1; c++) begin
						n = 0;
						for (int dr = -1; dr <= 1; dr++)
							for (int dc = -1; dc <= 1; dc++)
								if (dr != 0 || dc != 0) n += prev[r + dr][c + dc];
						cells[r][c] = prev[r][c] ? (n == 2 || n == 3) : (n == 3);
					end
				end
				gens = gens + 1'b1;
			end
			exp.row = (row < GRID_SIZE) ? field_row_t'(cells[row]) : '0;
			exp.count = gens;
			pending = {pending, exp};
		endfunction

		function void check_response(field_row_t row_out, logic [COUNT_W-1:0] count);
			life_rsp_t exp;
			if (pending.size() == 0) begin
				$error("unexpected response: row_out %h generation_count %0d", row_out, count);
				fails++;
				return;
			end
			exp = pending.pop_front();
			if (row_out !== exp.row) begin
				$error("row_out mismatch: expected %h, actual %h", exp.row, row_out);
				fails++;
			end
			if (count !== exp.count) begin
				$error("generation_count mismatch: expected %0d, actual %0d", exp.count, count);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lgs_in_if  cmd ();
	lgs_out_if rsp ();

	life_grid_generation_step uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	life_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int items_sent;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// response side: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp.ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_response(rsp.row_out, rsp.generation_count);
	end

	// called and returns at a falling edge; valid stays high until the next call
	task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [ROW_IDX_W-1:0] row,
		input field_row_t data);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.opcode    <= op;
		cmd.row_index <= row;
		cmd.row_cells <= data;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		sb.note_request(op, row, data);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		do @(negedge clk); while (sb.pending.size() != 0);
	endtask

	// load a random board, run some generations, then read it all back
	task automatic run_pattern();
		field_row_t v;
		for (int r = 0; r < GRID_SIZE; r++) begin
			if ($urandom_range(7) != 0) begin
				v = field_row_t'($urandom);
				if ($urandom_range(1)) v &= field_row_t'($urandom);
				send_cmd(OP_WRITE, ROW_IDX_W'(r), v);
			end
		end
		repeat ($urandom_range(1, 8)) begin
			send_cmd(OP_STEP, ROW_IDX_W'($urandom_range(GRID_SIZE - 1)),
				field_row_t'($urandom));
			if ($urandom_range(2) == 0)
				send_cmd(OP_READ, ROW_IDX_W'($urandom_range(GRID_SIZE - 1)),
					field_row_t'($urandom));
		end
		for (int r = 0; r < GRID_SIZE; r++)
			send_cmd(OP_READ, ROW_IDX_W'(r), field_row_t'($urandom));
	endtask

	task automatic send_noise(input int count);
		repeat (count)
			send_cmd(OPCODE_W'($urandom_range(3)), ROW_IDX_W'($urandom_range(15)),
				field_row_t'($urandom));
	endtask

	initial begin
		sb = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		items_sent     = 0;
		arst_n         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.opcode     = OP_WRITE;
		cmd.row_index  = '0;
		cmd.row_cells  = '0;
		rsp.ready      = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: borders, out-of-range rows, unused opcode, small oscillators
		send_cmd(OP_READ, 0, '0);
		send_cmd(OP_WRITE, 0, '1);
		send_cmd(OP_WRITE, 9, '1);
		send_cmd(OP_WRITE, 15, '1);
		send_cmd(OP_WRITE, 10, 10'h2AA);
		send_cmd(OP_READ, 13, '0);
		send_cmd(OP_UNUSED, 0, 10'h155);
		send_cmd(OP_UNUSED, 14, 10'h3FF);
		send_cmd(OP_WRITE, 2, 10'b0000001110);
		send_cmd(OP_STEP, 2, '0);
		send_cmd(OP_READ, 1, '0);
		send_cmd(OP_READ, 3, '0);
		send_cmd(OP_STEP, 15, '0);
		send_cmd(OP_WRITE, 5, 10'h3FF);
		send_cmd(OP_WRITE, 4, '0);
		send_cmd(OP_STEP, 5, '0);
		send_cmd(OP_READ, 4, '0);
		send_cmd(OP_READ, 6, '0);
		send_cmd(OP_WRITE, 6, 10'h155);
		send_cmd(OP_WRITE, 7, 10'h2AA);
		send_cmd(OP_STEP, 6, 10'h3FF);
		send_cmd(OP_READ, 7, '0);
		send_cmd(OP_READ, 9, '0);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			while (items_sent < (phase + 1) * ITEMS_PER_PHASE) begin
				if ($urandom_range(4) == 0) send_noise($urandom_range(1, 8));
				else run_pattern();
				// long receiver hold while requests keep coming, backs up the input
				if ((phase == 0 || phase == 3) && $urandom_range(5) == 0) hold_cycles = 40;
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (sb.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
src/lgs_pkg.sv
src/lgs_in_if.sv
src/lgs_out_if.sv
src/lgs_ctrl.sv
src/lgs_dp.sv
src/life_grid_generation_step.sv
tb/sv/tb.sv
